### rtl/bmq_pkg.sv
// Package for the blocking message queue: field widths, request and status
// codes, the command type passed from controller to datapath and the datapath result type.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bmq_pkg;

  localparam int TASK_W   = 4;
  localparam int DATA_W   = 32;
  localparam int TICK_W   = 32;
  localparam int STATUS_W = 2;
  localparam int QLEN_W   = 5;

  localparam logic [QLEN_W-1:0] QLEN_RESET = 5'd16;

  localparam int DEFAULT_DEPTH     = 16;
  localparam int DEFAULT_ITEM_BITS = 32;
  localparam int DEFAULT_TASKS     = 16;

  localparam logic REQ_SEND = 1'b0;
  localparam logic REQ_RECV = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_BLOCKED = 2'd1;
  localparam status_t ST_FULL    = 2'd2;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] item_out;
    logic              wake_valid;
    logic [TASK_W-1:0] wake_task;
    logic              delay_valid;
    logic [TICK_W-1:0] delay_ticks;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/bmq_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on bmq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bmq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [bmq_pkg::TASK_W-1:0] task_id;
  logic [bmq_pkg::DATA_W-1:0] item_data;
  logic [bmq_pkg::TICK_W-1:0] timeout_ticks;

  modport source (output valid, req_type, task_id, item_data, timeout_ticks, input ready);
  modport sink   (input valid, req_type, task_id, item_data, timeout_ticks, output ready);
endinterface

interface bmq_rsp_if;
  logic                       valid;
  logic                       ready;
  bmq_pkg::status_t           status;
  logic [bmq_pkg::DATA_W-1:0] item_out;
  logic                       wake_valid;
  logic [bmq_pkg::TASK_W-1:0] wake_task;
  logic                       delay_valid;
  logic [bmq_pkg::TICK_W-1:0] delay_ticks;

  modport source (output valid, status, item_out, wake_valid, wake_task, delay_valid,
                  delay_ticks, input ready);
  modport sink   (input valid, status, item_out, wake_valid, wake_task, delay_valid,
                  delay_ticks, output ready);
endinterface

`default_nettype wire

### rtl/bmq_ctrl.sv
// Controller for the message queue: takes a request word, has the datapath
// execute it in the execute state and holds the response word until it is taken.
// Depends on bmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bmq_pkg::ctrl_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_RESP);
  assign cmd.capture = in_valid && (state_r == S_IDLE);
  assign cmd.execute = (state_r == S_EXEC);

  // An executed request always shows its response in the next cycle.
  a_exec_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid)
    else $error("execute cycle not followed by a response");

  // No new word is taken while a response is pending.
  a_no_take_while_resp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !cmd.capture)
    else $error("request captured while a response is pending");

endmodule

`default_nettype wire

### rtl/bmq_datapath.sv
// Datapath for the message queue: request registers, ring store, both wait
// stacks, indices and counters, and the response registers.
// Depends on bmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmq_datapath #(
  parameter int DEPTH     = bmq_pkg::DEFAULT_DEPTH,
  parameter int ITEM_BITS = bmq_pkg::DEFAULT_ITEM_BITS,
  parameter int TASKS     = bmq_pkg::DEFAULT_TASKS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bmq_pkg::ctrl_cmd_t           cmd,
  input  wire logic                         cfg_we,
  input  wire logic [bmq_pkg::QLEN_W-1:0]   cfg_wdata,
  input  wire logic                         req_type,
  input  wire logic [bmq_pkg::TASK_W-1:0]   task_id,
  input  wire logic [bmq_pkg::DATA_W-1:0]   item_data,
  input  wire logic [bmq_pkg::TICK_W-1:0]   timeout_ticks,
  output bmq_pkg::rsp_t                     rsp
);

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SP_W   = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int WC_W   = $clog2(TASKS + 1);
  localparam int KEEP_W = (ITEM_BITS < bmq_pkg::DATA_W) ? ITEM_BITS : bmq_pkg::DATA_W;

  // Captured request.
  logic                         req_type_r;
  logic [bmq_pkg::TASK_W-1:0]   task_r;
  logic [bmq_pkg::DATA_W-1:0]   item_r;
  logic [bmq_pkg::TICK_W-1:0]   ticks_r;

  // Queue state.
  logic [bmq_pkg::QLEN_W-1:0]   qlen_r;
  logic [IDX_W-1:0]             wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]             rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]             fill_r, fill_nxt;
  logic [WC_W-1:0]              swc_r, swc_nxt;
  logic [WC_W-1:0]              rwc_r, rwc_nxt;

  // Memories.
  logic [ITEM_BITS-1:0]         slot_mem [DEPTH];
  logic [bmq_pkg::TASK_W-1:0]   send_stack [TASKS];
  logic [bmq_pkg::TASK_W-1:0]   recv_stack [TASKS];
  logic [ITEM_BITS-1:0]         slot_rd_r;
  logic [bmq_pkg::TASK_W-1:0]   send_rd_r;
  logic [bmq_pkg::TASK_W-1:0]   recv_rd_r;

  // Response registers.
  bmq_pkg::status_t             status_r;
  logic                         recv_ok_r;
  logic                         wake_valid_r;
  logic                         wake_from_send_r;
  logic                         delay_valid_r;
  logic [bmq_pkg::TICK_W-1:0]   delay_ticks_r;

  // Execute-cycle decode.
  logic [CNT_W-1:0]             len;
  logic                         is_recv;
  logic                         blocked;
  logic [WC_W-1:0]              own_cnt;
  logic [WC_W-1:0]              opp_cnt;
  logic                         stack_full;
  logic                         do_push;
  logic                         do_wake;
  logic                         do_send;
  logic                         do_recv;
  logic [CNT_W-1:0]             wr_inc;
  logic [CNT_W-1:0]             rd_inc;
  logic [ITEM_BITS-1:0]         wr_item;
  logic [bmq_pkg::DATA_W-1:0]   rd_item;

  // Length zero acts as one slot; anything above the built depth acts as the depth.
  always_comb begin
    if (qlen_r == '0) begin
      len = CNT_W'(1);
    end else if (32'(qlen_r) > 32'(DEPTH)) begin
      len = CNT_W'(DEPTH);
    end else begin
      len = CNT_W'(qlen_r);
    end
  end

  always_comb begin
    is_recv    = (req_type_r == bmq_pkg::REQ_RECV);
    blocked    = is_recv ? (fill_r == '0) : (fill_r >= len);
    own_cnt    = is_recv ? rwc_r : swc_r;
    opp_cnt    = is_recv ? swc_r : rwc_r;
    stack_full = (own_cnt == WC_W'(TASKS));
    do_push    = cmd.execute && blocked && !stack_full;
    do_wake    = cmd.execute && !blocked && (opp_cnt != '0);
    do_send    = cmd.execute && !blocked && !is_recv;
    do_recv    = cmd.execute && !blocked && is_recv;
    wr_inc     = CNT_W'(wr_idx_r) + CNT_W'(1);
    rd_inc     = CNT_W'(rd_idx_r) + CNT_W'(1);
  end

  always_comb begin
    wr_item = '0;
    wr_item[KEEP_W-1:0] = item_r[KEEP_W-1:0];
    rd_item = '0;
    rd_item[KEEP_W-1:0] = slot_rd_r[KEEP_W-1:0];
  end

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    fill_nxt   = fill_r;
    swc_nxt    = swc_r;
    rwc_nxt    = rwc_r;
    if (cfg_we) begin
      wr_idx_nxt = '0;
      rd_idx_nxt = '0;
      fill_nxt   = '0;
      swc_nxt    = '0;
      rwc_nxt    = '0;
    end else begin
      if (do_send) begin
        wr_idx_nxt = (wr_inc >= len) ? '0 : wr_inc[IDX_W-1:0];
        fill_nxt   = fill_r + CNT_W'(1);
      end
      if (do_recv) begin
        rd_idx_nxt = (rd_inc >= len) ? '0 : rd_inc[IDX_W-1:0];
        fill_nxt   = fill_r - CNT_W'(1);
      end
      // A push lands on the requester's own stack, a wake pops the other one.
      if (do_push) begin
        if (is_recv) rwc_nxt = rwc_r + WC_W'(1);
        else         swc_nxt = swc_r + WC_W'(1);
      end
      if (do_wake) begin
        if (is_recv) swc_nxt = swc_r - WC_W'(1);
        else         rwc_nxt = rwc_r - WC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r   <= bmq_pkg::QLEN_RESET;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      fill_r   <= '0;
      swc_r    <= '0;
      rwc_r    <= '0;
    end else begin
      if (cfg_we) qlen_r <= cfg_wdata;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      fill_r   <= fill_nxt;
      swc_r    <= swc_nxt;
      rwc_r    <= rwc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r <= req_type;
      task_r     <= task_id;
      item_r     <= item_data;
      ticks_r    <= timeout_ticks;
    end
  end

  // Ring store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_send) slot_mem[wr_idx_r] <= wr_item;
    if (do_recv) slot_rd_r <= slot_mem[rd_idx_r];
  end

  // Sender wait stack.
  always_ff @(posedge clk) begin
    if (do_push && !is_recv) send_stack[swc_r[SP_W-1:0]] <= task_r;
    if (do_wake && is_recv) send_rd_r <= send_stack[swc_nxt[SP_W-1:0]];
  end

  // Receiver wait stack.
  always_ff @(posedge clk) begin
    if (do_push && is_recv) recv_stack[rwc_r[SP_W-1:0]] <= task_r;
    if (do_wake && !is_recv) recv_rd_r <= recv_stack[rwc_nxt[SP_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (!blocked) begin
        status_r <= bmq_pkg::ST_DONE;
      end else if (stack_full) begin
        status_r <= bmq_pkg::ST_FULL;
      end else begin
        status_r <= bmq_pkg::ST_BLOCKED;
      end
      recv_ok_r        <= do_recv;
      wake_valid_r     <= do_wake;
      wake_from_send_r <= is_recv;
      delay_valid_r    <= do_push && (ticks_r != '0);
      delay_ticks_r    <= (do_push && (ticks_r != '0)) ? ticks_r : '0;
    end
  end

  always_comb begin
    rsp.status      = status_r;
    rsp.item_out    = recv_ok_r ? rd_item : '0;
    rsp.wake_valid  = wake_valid_r;
    if (!wake_valid_r) begin
      rsp.wake_task = '0;
    end else if (wake_from_send_r) begin
      rsp.wake_task = send_rd_r;
    end else begin
      rsp.wake_task = recv_rd_r;
    end
    rsp.delay_valid = delay_valid_r;
    rsp.delay_ticks = delay_ticks_r;
  end

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len)
    else $error("fill count exceeds the active queue length");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(wr_idx_r) < len) && (CNT_W'(rd_idx_r) < len))
    else $error("ring index outside the active queue length");

  a_wait_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (swc_r <= WC_W'(TASKS)) && (rwc_r <= WC_W'(TASKS)))
    else $error("wait stack count above the number of tasks");

  a_push_wake_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_push && do_wake))
    else $error("push and wake in the same request");

endmodule

`default_nettype wire

### rtl/blocking_message_queue_core.sv
// Blocking message queue for tasks: a ring of items with two wait stacks.
// Usage:
//   in_req carries request words (req_type, task_id, item_data, timeout_ticks);
//   out_rsp carries exactly one response word per request (status, item_out,
//   wake_valid, wake_task, delay_valid, delay_ticks). Both use valid/ready.
//   A send stores the item if there is room and wakes the most recent waiting
//   receiver; a receive takes the oldest item and wakes the most recent waiting
//   sender. A request that cannot be served pushes its task on a wait stack and
//   returns a nonzero timeout for an external delay list, or reports a full stack.
// Timing:
//   After the request word is taken, the execute state runs and then the
//   response is valid. One request is in flight at a time, so no new word is
//   taken until the response is; the response waits on the registered read
//   ports of the ring store and the wait stacks, read in the execute cycle.
//   If the receiver stalls, the response holds and in_req.ready stays low.
// Reset and configuration:
//   After reset the queue and both stacks are empty and the length is 16;
//   memories need no clearing pass. A cfg_we write sets the length and empties
//   queue and stacks; issue it only with no request in flight (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module blocking_message_queue_core #(
  parameter int DEPTH     = bmq_pkg::DEFAULT_DEPTH,
  parameter int ITEM_BITS = bmq_pkg::DEFAULT_ITEM_BITS,
  parameter int TASKS     = bmq_pkg::DEFAULT_TASKS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bmq_req_if.sink                          in_req,
  bmq_rsp_if.source                        out_rsp,
  input  wire logic                        cfg_we,
  input  wire logic [bmq_pkg::QLEN_W-1:0]  cfg_wdata
);

  bmq_pkg::ctrl_cmd_t cmd;
  bmq_pkg::rsp_t      rsp;
  logic               in_ready;
  logic               out_valid;

  bmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  bmq_datapath #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS),
    .TASKS     (TASKS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req_type      (in_req.req_type),
    .task_id       (in_req.task_id),
    .item_data     (in_req.item_data),
    .timeout_ticks (in_req.timeout_ticks),
    .rsp           (rsp)
  );

  assign in_req.ready        = in_ready;
  assign out_rsp.valid       = out_valid;
  assign out_rsp.status      = rsp.status;
  assign out_rsp.item_out    = rsp.item_out;
  assign out_rsp.wake_valid  = rsp.wake_valid;
  assign out_rsp.wake_task   = rsp.wake_task;
  assign out_rsp.delay_valid = rsp.delay_valid;
  assign out_rsp.delay_ticks = rsp.delay_ticks;

endmodule

`default_nettype wire
